// ===== design/earliest_free_worker_dispatch_unit_defines.svh =====
// assertion macros for the dispatch unit
`ifndef EARLIEST_FREE_WORKER_DISPATCH_UNIT_DEFINES_SVH
`define EARLIEST_FREE_WORKER_DISPATCH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define EFWD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dispatch unit check failed");
`define EFWD_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("dispatch unit reset check failed");
`else
`define EFWD_ASSERT(lbl, prop)
`define EFWD_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/efwd_pkg.sv =====
`timescale 1ns / 1ps
package efwd_pkg;
	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	localparam int CFG_W   = 7;
	localparam int DUR_W   = 32;
	localparam int WIDX_W  = 6;
	localparam int START_W = 48;
	localparam int OUT_W   = 56;
endpackage

// ===== design/earliest_free_worker_dispatch_unit.sv =====
`timescale 1ns / 1ps
// Dispatches each job (s_tdata = duration) to the active worker that is free
// earliest, lowest index on ties, and returns that worker and the job's start
// time; the worker's free time then grows by the duration, saturating at
// 2^TIME_BITS-1. Free times live in one synchronous memory with one read port;
// each job sweeps the active workers one read per cycle; with n the active count
// after clamping to 1..MAX_WORKERS, a job runs n sweep reads, one read stage and
// one update that loads the result beat, and the next job is taken only after
// that update, so a new job is not accepted while one is in flight. A result that is
// still waiting in the output register holds the update, and with it the input.
// Reset needs no clearing pass: per-worker valid bits make unwritten entries read 0.
// active_workers (cfg_data) may only be written while no job is in flight.
`include "earliest_free_worker_dispatch_unit_defines.svh"
module earliest_free_worker_dispatch_unit
	import efwd_pkg::*;
#(
	parameter int MAX_WORKERS = 64,
	parameter int TIME_BITS   = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,   // active_workers
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DUR_W-1:0]   s_tdata,    // job_duration
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata     // worker_index [5:0], start_time [53:6], zero pad
);

	localparam int IDXW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CNTW = IDXW + 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	state_t state_q, state_d;
	logic [CFG_W-1:0]     act_q;
	logic [CNTW-1:0]      n_eff;
	logic [CNTW-1:0]      cnt_q;
	logic [DUR_W-1:0]     dur_q;
	logic [TIME_BITS-1:0] mem [MAX_WORKERS];
	logic [MAX_WORKERS-1:0] vld_q;
	logic [TIME_BITS-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic                 rd_en_s1;
	logic [IDXW-1:0]      rd_idx_s1;
	logic [TIME_BITS-1:0] best_time_q;
	logic [IDXW-1:0]      best_idx_q;
	logic                 best_any_q;
	logic [TIME_BITS-1:0] cand;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] new_time;
	logic                 in_acc;
	logic                 issue;
	logic                 finish;
	logic                 out_vld_q;
	logic [OUT_W-1:0]     out_q;

	// effective worker count
	always_comb begin
		if (act_q == '0) begin
			n_eff = CNTW'(1);
		end else if (32'(act_q) > 32'(MAX_WORKERS)) begin
			n_eff = CNTW'(MAX_WORKERS);
		end else begin
			n_eff = CNTW'(act_q);
		end
	end

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= CFG_W'(64);
		end else if (cfg_valid) begin
			act_q <= cfg_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_q == n_eff - CNTW'(1)) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (!out_vld_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: issue = 1'b1;
			ST_DONE: finish = !out_vld_q || m_tready;
			default: ;
		endcase
	end

	assign in_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep counter and job latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dur_q <= s_tdata;
		end
	end

	// free-time memory, one read and one write port
	always_ff @(posedge clk) begin
		if (finish) begin
			mem[best_idx_q] <= new_time;
		end
		rd_data_s1 <= mem[cnt_q[IDXW-1:0]];
		rd_idx_s1  <= cnt_q[IDXW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_en_s1  <= 1'b0;
		end else begin
			if (finish) begin
				vld_q[best_idx_q] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[cnt_q[IDXW-1:0]];
			rd_en_s1  <= issue;
		end
	end

	// running minimum, strict compare keeps the lowest index on ties
	assign cand = rd_vld_s1 ? rd_data_s1 : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_any_q <= 1'b0;
		end else if (in_acc) begin
			best_any_q <= 1'b0;
		end else if (rd_en_s1) begin
			best_any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_s1 && (!best_any_q || cand < best_time_q)) begin
			best_time_q <= cand;
			best_idx_q  <= rd_idx_s1;
		end
	end

	// saturating update of the chosen worker
	assign sum      = {1'b0, best_time_q} + (TIME_BITS+1)'(dur_q);
	assign new_time = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= {(OUT_W-WIDX_W-START_W)'(0), START_W'(best_time_q),
				WIDX_W'(best_idx_q)};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// checks
	`EFWD_ASSERT(a_accept_starts_scan, in_acc |=> state_q == ST_SCAN)
	`EFWD_ASSERT(a_scan_in_range, issue |-> cnt_q < n_eff)
	`EFWD_ASSERT(a_pick_active, finish |-> CNTW'(best_idx_q) < n_eff)
	`EFWD_ASSERT(a_finish_shows_beat, finish |=> m_tvalid)
	`EFWD_ASSERT_RST(a_reset_idle, !arst_n |-> state_q == ST_IDLE)

endmodule
